/* rtl/pmst_pkg.sv */
// Package for the Prim spanning tree engine: sizes, codes and payload types.
// Used by every module under rtl/.
package pmst_pkg;

   localparam int MaxVertices = 32;
   localparam int MaxEdges    = 256;
   localparam int VW = 6;
   localparam int WW = 20;
   localparam int VIW = $clog2(MaxVertices);
   localparam int EIW = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
   localparam int ECW = $clog2(MaxEdges + 1);

   localparam logic [1:0] ActAdd   = 2'd0;
   localparam logic [1:0] ActRun   = 2'd1;
   localparam logic [1:0] ActClear = 2'd2;

   localparam logic CsrVertexCount = 1'b0;
   localparam logic CsrStartVertex = 1'b1;

   typedef struct packed {
      logic [1:0]    action;
      logic [VW-1:0] edge_from;
      logic [VW-1:0] edge_to;
      logic [WW-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [VW-1:0] vertex_index;
      logic [VW-1:0] parent_vertex;
      logic [WW-1:0] key_weight;
      logic          reachable;
      logic          edges_dropped;
      logic          last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_SEARCH, ST_RELAX, ST_RDWAIT, ST_EMIT
   } state_type;

endpackage

/* rtl/prim_minimum_spanning_tree.sv */
// Prim spanning tree engine: top level with edge store and run sequencer.
// Depends on pmst_pkg.
// Add and clear requests are handled in the idle state. A run first sets up
// the key, parent and done entries of all MaxVertices vertices. Each round
// then scans the nv active vertices for the lowest key not yet in the tree
// and relaxes every stored edge. A final search that finds no reachable
// vertex is followed by nv output transactions. Ready is low during a run.
// Reset is synchronous; the edge store is not cleared, only its count.
module prim_minimum_spanning_tree
   import pmst_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [6:0]    csr_data
);

   logic [6:0]      vcount_ff;
   logic [VW-1:0]   start_ff;
   logic [ECW-1:0]  nedge_ff;
   logic            drop_ff;
   state_type       state_ff, state_in;

   logic [VW-1:0] mem_from [MaxEdges];
   logic [VW-1:0] mem_to   [MaxEdges];
   logic [WW-1:0] mem_w    [MaxEdges];
   logic [VW-1:0] rd_from_ff, rd_to_ff;
   logic [WW-1:0] rd_w_ff;

   logic [WW:0]      key_ff    [MaxVertices];
   logic [VW-1:0]    par_ff    [MaxVertices];
   logic [MaxVertices-1:0] done_ff;

   logic [VW:0]     idx_ff;     // vertex scan index
   logic [ECW-1:0]  eidx_ff;    // edge scan index
   logic [VW:0]     best_ff;
   logic [WW:0]     bkey_ff;
   logic [VW-1:0]   u_ff;
   logic            rdv_ff;     // registered read data valid

   logic [6:0] nv;
   logic [VW-1:0] s_vtx;
   always_comb begin
      if (vcount_ff == 7'd0) nv = 7'd1;
      else if (vcount_ff > 7'(MaxVertices)) nv = 7'(MaxVertices);
      else nv = vcount_ff;
      s_vtx = (7'(start_ff) < nv) ? start_ff : '0;
   end

   logic req_fire, rsp_fire;
   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Edge relax compare on the registered read data.
   logic [VW-1:0] other;
   logic hit, better;
   always_comb begin
      hit = 1'b0;
      other = rd_to_ff;
      if (7'(rd_from_ff) < nv && 7'(rd_to_ff) < nv) begin
         if (rd_from_ff == u_ff) begin
            hit = 1'b1; other = rd_to_ff;
         end else if (rd_to_ff == u_ff) begin
            hit = 1'b1; other = rd_from_ff;
         end
      end
      better = hit && !done_ff[other[VIW-1:0]] &&
               ({1'b0, rd_w_ff} < key_ff[other[VIW-1:0]]);
   end

   logic scan_more;
   assign scan_more = eidx_ff < nedge_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire && req_data.action == ActRun) state_in = ST_INIT;
         ST_INIT:   if (idx_ff == 7'(MaxVertices - 1)) state_in = ST_SEARCH;
         ST_SEARCH: begin
            if (7'(idx_ff) == nv) begin
               if (best_ff >= VW'(0) + 7'(nv) || bkey_ff[WW]) state_in = ST_EMIT;
               else state_in = ST_RELAX;
            end
         end
         ST_RELAX:  state_in = scan_more ? ST_RDWAIT : ST_SEARCH;
         ST_RDWAIT: state_in = ST_RELAX;
         ST_EMIT:   if (rsp_fire && 7'(idx_ff) + 7'd1 == nv) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      rsp_data.vertex_index  = idx_ff[VW-1:0];
      rsp_data.reachable     = done_ff[idx_ff[VIW-1:0]];
      rsp_data.parent_vertex = rsp_data.reachable ? par_ff[idx_ff[VIW-1:0]] : idx_ff[VW-1:0];
      rsp_data.key_weight    = rsp_data.reachable ? key_ff[idx_ff[VIW-1:0]][WW-1:0] : '0;
      rsp_data.edges_dropped = drop_ff;
      rsp_data.last          = (7'(idx_ff) + 7'd1 == nv);
   end

   // Edge store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (req_fire && req_data.action == ActAdd && !(7'(req_data.edge_from) >= nv ||
          7'(req_data.edge_to) >= nv || nedge_ff >= ECW'(MaxEdges))) begin
         mem_from[nedge_ff[EIW-1:0]] <= req_data.edge_from;
         mem_to[nedge_ff[EIW-1:0]]   <= req_data.edge_to;
         mem_w[nedge_ff[EIW-1:0]]    <= req_data.edge_weight;
      end
      rd_from_ff <= mem_from[eidx_ff[EIW-1:0]];
      rd_to_ff   <= mem_to[eidx_ff[EIW-1:0]];
      rd_w_ff    <= mem_w[eidx_ff[EIW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         vcount_ff <= 7'd30;
         start_ff  <= '0;
         nedge_ff  <= '0;
         drop_ff   <= 1'b0;
         idx_ff    <= '0;
         eidx_ff   <= '0;
         rdv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_index == CsrVertexCount) vcount_ff <= csr_data;
            else start_ff <= csr_data[VW-1:0];
         end
         rdv_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (req_fire) begin
                  if (req_data.action == ActAdd) begin
                     if (7'(req_data.edge_from) >= nv || 7'(req_data.edge_to) >= nv ||
                         nedge_ff >= ECW'(MaxEdges)) drop_ff <= 1'b1;
                     else nedge_ff <= nedge_ff + 1'b1;
                  end else if (req_data.action == ActClear) begin
                     nedge_ff <= '0;
                     drop_ff  <= 1'b0;
                  end
               end
            end
            ST_INIT: begin
               key_ff[idx_ff[VIW-1:0]]  <= (idx_ff[VW-1:0] == s_vtx) ? '0 : {1'b1, {WW{1'b0}}};
               par_ff[idx_ff[VIW-1:0]]  <= idx_ff[VW-1:0];
               done_ff[idx_ff[VIW-1:0]] <= 1'b0;
               if (idx_ff == 7'(MaxVertices - 1)) begin
                  idx_ff  <= '0;
                  best_ff <= nv;
                  bkey_ff <= {1'b1, {WW{1'b0}}};
               end else idx_ff <= idx_ff + 1'b1;
            end
            ST_SEARCH: begin
               if (7'(idx_ff) == nv) begin
                  if (state_in == ST_RELAX) begin
                     done_ff[best_ff[VIW-1:0]] <= 1'b1;
                     u_ff    <= best_ff[VW-1:0];
                     eidx_ff <= '0;
                  end
                  idx_ff <= '0;
               end else begin
                  if (!done_ff[idx_ff[VIW-1:0]] && key_ff[idx_ff[VIW-1:0]] < bkey_ff) begin
                     bkey_ff <= key_ff[idx_ff[VIW-1:0]];
                     best_ff <= idx_ff;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_RELAX: begin
               if (rdv_ff && better) begin
                  key_ff[other[VIW-1:0]] <= {1'b0, rd_w_ff};
                  par_ff[other[VIW-1:0]] <= u_ff;
               end
               if (!scan_more) begin
                  best_ff <= nv;
                  bkey_ff <= {1'b1, {WW{1'b0}}};
               end
            end
            ST_RDWAIT: begin
               rdv_ff  <= 1'b1;
               eidx_ff <= eidx_ff + 1'b1;
            end
            ST_EMIT: if (rsp_fire) idx_ff <= idx_ff + 1'b1;
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("response offered while accepting requests");
   assert property (@(posedge clock) disable iff (reset) nedge_ff <= ECW'(MaxEdges))
      else $error("edge count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data.last) |=> state_ff == ST_IDLE)
      else $error("run did not finish after last result");

endmodule

/* tb/sv/tb_prim_minimum_spanning_tree.sv */
`timescale 1ns / 1ps
// Testbench for prim_minimum_spanning_tree: a self-checking predictor of the
// spanning tree, random handshake stalls on both sides. Depends on pmst_pkg.
module tb_prim_minimum_spanning_tree;
   import pmst_pkg::*;

   localparam logic [1:0] ActIdle = 2'd3;
   localparam logic [20:0] KeyInf = 21'h100000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_index = CsrVertexCount;
   logic [6:0] csr_data = '0;

   prim_minimum_spanning_tree u_top (.*);

   always #6 clock = ~clock;

   // Mirror of the block's edge store, flag and registers.
   logic [VW-1:0] edge_a [MaxEdges];
   logic [VW-1:0] edge_b [MaxEdges];
   logic [WW-1:0] edge_w [MaxEdges];
   int            edge_cnt = 0;
   bit            drop_seen = 0;
   logic [6:0]    cfg_count = 7'd30;
   logic [5:0]    cfg_start = 6'd0;

   rsp_type tree_results [$];
   int      mismatches = 0;
   int      results_seen = 0;
   int      runs_sent = 0;
   int      adds_sent = 0;
   int      ready_hold = 0;
   bit      calm = 0;

   function automatic int active_count();
      if (cfg_count == 0) return 1;
      if (cfg_count > MaxVertices) return MaxVertices;
      return cfg_count;
   endfunction

   function automatic void grow_tree();
      int nv, root, best, other;
      logic [20:0] key [MaxVertices];
      logic [VW-1:0] par [MaxVertices];
      bit done [MaxVertices];
      logic [20:0] best_key;
      rsp_type r;
      nv = active_count();
      root = (cfg_start < nv) ? cfg_start : 0;
      for (int i = 0; i < MaxVertices; i++) begin
         key[i] = KeyInf;
         par[i] = VW'(i);
         done[i] = 0;
      end
      key[root] = 0;
      for (int round = 0; round < nv; round++) begin
         best = nv;
         best_key = KeyInf;
         for (int i = 0; i < nv; i++)
            if (!done[i] && key[i] < best_key) begin
               best_key = key[i];
               best = i;
            end
         if (best >= nv) break;
         done[best] = 1;
         for (int e = 0; e < edge_cnt; e++) begin
            if (edge_a[e] >= nv || edge_b[e] >= nv) continue;
            if (edge_a[e] == best) other = edge_b[e];
            else if (edge_b[e] == best) other = edge_a[e];
            else continue;
            if (!done[other] && {1'b0, edge_w[e]} < key[other]) begin
               key[other] = {1'b0, edge_w[e]};
               par[other] = VW'(best);
            end
         end
      end
      for (int i = 0; i < nv; i++) begin
         r.vertex_index = VW'(i);
         r.parent_vertex = done[i] ? par[i] : VW'(i);
         r.key_weight = done[i] ? key[i][WW-1:0] : '0;
         r.reachable = done[i];
         r.edges_dropped = drop_seen;
         r.last = (i + 1 == nv);
         tree_results = {tree_results, r};
      end
   endfunction

   function automatic void apply_action(req_type t);
      case (t.action)
         ActAdd: begin
            adds_sent++;
            if (t.edge_from >= active_count() || t.edge_to >= active_count() ||
                edge_cnt >= MaxEdges) begin
               drop_seen = 1;
            end else begin
               edge_a[edge_cnt] = t.edge_from;
               edge_b[edge_cnt] = t.edge_to;
               edge_w[edge_cnt] = t.edge_weight;
               edge_cnt++;
            end
         end
         ActRun: begin
            runs_sent++;
            grow_tree();
         end
         ActClear: begin
            edge_cnt = 0;
            drop_seen = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic int draw_gap();
      if (calm) return 0;
      return $urandom_range(0, 15);
   endfunction

   task automatic send_item(input logic [1:0] act, input int a, input int b, input int w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{action: act, edge_from: a[5:0], edge_to: b[5:0],
                    edge_weight: w[19:0]};
      do @(posedge clock); while (!req_ready);
      apply_action('{action: act, edge_from: a[5:0], edge_to: b[5:0],
                     edge_weight: w[19:0]});
   endtask

   // Waits until every expected result is in, then lets the block settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tree_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_config(input int count, input int start);
      wait_idle();
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= CsrVertexCount;
      csr_data <= count[6:0];
      @(posedge clock);
      csr_index <= CsrStartVertex;
      csr_data <= {1'b0, start[5:0]};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_count = count[6:0];
      cfg_start = start[5:0];
   endtask

   task automatic add_edge(input int a, input int b, input int w);
      send_item(ActAdd, a, b, w);
   endtask

   // Result side: random stalls and the field-by-field check.
   always @(posedge clock) begin : rsp_side
      rsp_type want;
      int hold;
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         results_seen++;
         if (tree_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transaction: %p", rsp_data);
         end else begin
            want = tree_results.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, got %p", want, rsp_data);
            end
         end
         hold = draw_gap();
         if (hold == 0) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            ready_hold = hold - 1;
         end
      end else if (!rsp_ready) begin
         if (ready_hold == 0) rsp_ready <= 1'b1;
         else ready_hold--;
      end
   end

   task automatic test_small_graphs();
      set_config(4, 0);
      add_edge(0, 1, 5);
      add_edge(1, 2, 0);
      add_edge(0, 2, 5);
      add_edge(2, 2, 0);               // self loop
      add_edge(2, 3, 20'hFFFFF);
      add_edge(3, 1, 20'hFFFFF);       // equal weight: the edge relaxed first wins
      add_edge(63, 0, 1);              // out of range, sets the drop flag
      send_item(ActIdle, 63, 63, 20'hFFFFF);
      send_item(ActRun, 0, 0, 0);
      set_config(4, 63);               // start out of range falls back to vertex 0
      send_item(ActRun, 0, 0, 0);
      set_config(4, 3);
      send_item(ActRun, 0, 0, 0);
      send_item(ActClear, 0, 0, 0);
      send_item(ActRun, 0, 0, 0);      // nothing reachable but the start
      set_config(0, 0);
      send_item(ActRun, 0, 0, 0);
   endtask

   task automatic test_stale_edges();
      set_config(8, 2);
      add_edge(7, 2, 3);
      add_edge(2, 1, 9);
      add_edge(1, 7, 1);
      add_edge(0, 1, 4);
      set_config(3, 2);                // edges at vertex 7 now ignored
      send_item(ActRun, 0, 0, 0);
      set_config(127, 31);             // clamps to the largest graph
      send_item(ActRun, 0, 0, 0);
   endtask

   task automatic test_random_graphs();
      int nv, pick;
      for (int phase = 0; phase < 8; phase++) begin
         nv = (phase == 7) ? 32 : $urandom_range(1, 12);
         set_config(nv, $urandom_range(0, 63));
         calm = (phase == 3);
         send_item(ActClear, 0, 0, 0);
         for (int k = 0; k < 8; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
               add_edge($urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
                        (pick < 8) ? $urandom_range(0, 15) : $urandom_range(0, 20'hFFFFF));
            else if (pick < 18)
               add_edge($urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 20'hFFFFF));
            else
               send_item(ActIdle, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 20'hFFFFF));
         end
         send_item(ActRun, 0, 0, 0);
         if (phase % 2) send_item(ActRun, 0, 0, 0);
      end
      calm = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_graphs();
      test_stale_edges();
      test_random_graphs();
      req_valid <= 1'b0;
      while (tree_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d add transactions and %0d runs; checked %0d result transactions.",
               adds_sent, runs_sent, results_seen);
      $display("Mismatches: %0d.", mismatches);
      if (mismatches == 0 && tree_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Timeout with %0d results outstanding.", tree_results.size());
      $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
rtl/pmst_pkg.sv
rtl/prim_minimum_spanning_tree.sv
tb/sv/tb_prim_minimum_spanning_tree.sv
